// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// The consequent must hold after the antecedent, with the delay given by dly.
`define ASSERT_DELAYED(label, clk, rst, pre, dly, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##dly (post)) \
      else $error("delayed check failed");

`endif

// ----- design/tnc_pkg.sv -----
// Types, constants and step functions for the triangle normal and centroid pipeline.
package tnc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int EDGE_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = PROD_W;
   localparam int NCHUNK      = (MAG_W + 7) / 8;
   localparam int BL_W        = $clog2(NCHUNK * 8 + 1);
   localparam int SUM_W       = COORD_WIDTH + 2;
   localparam int DIV3_SHIFT  = SUM_W + 2;
   localparam int MULT_W      = DIV3_SHIFT - 1;
   localparam int CPROD_W     = SUM_W + MULT_W;
   localparam logic [63:0] DIV3_MULT = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;

   localparam int NORM_W      = 32;
   localparam int NORM_FRAC   = 30;
   localparam int M_W         = 31;
   localparam int ROOT_W      = 32;
   localparam int SQ_W        = 2 * ROOT_W;
   localparam int STEPS       = 4;
   localparam int ROOT_STAGES = ROOT_W / STEPS;
   localparam int DIV_STAGES  = ROOT_W / STEPS;
   localparam int CROSS_STAGES = 3;
   localparam int NORM_STAGES  = 5;
   localparam int LATENCY = CROSS_STAGES + NORM_STAGES + ROOT_STAGES + 1 + DIV_STAGES + 1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] first_z;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic signed [COORD_WIDTH-1:0] second_z;
      logic signed [COORD_WIDTH-1:0] third_x;
      logic signed [COORD_WIDTH-1:0] third_y;
      logic signed [COORD_WIDTH-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0]      normal_x;
      logic signed [NORM_W-1:0]      normal_y;
      logic signed [NORM_W-1:0]      normal_z;
      logic signed [COORD_WIDTH-1:0] centroid_x;
      logic signed [COORD_WIDTH-1:0] centroid_y;
      logic signed [COORD_WIDTH-1:0] centroid_z;
      logic                          degenerate;
   } rsp_type;

   // Values that ride along the pipeline next to the normal math.
   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] centroid;
      logic [2:0]                  neg;
      logic                        degenerate;
   } side_type;

   typedef logic [2:0][CROSS_W-1:0] cross_vec_type;
   typedef logic [2:0][M_W-1:0]     mvec_type;
   typedef logic [2:0][ROOT_W-1:0]  qvec_type;

   typedef struct packed {
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   rad;
   } sqrt_state_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] low;
      logic [ROOT_W-1:0] quo;
   } div_state_type;

   // One digit of the bitwise integer square root.
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      sqrt_state_type    r;
      logic [ROOT_W+1:0] rem2;
      logic [ROOT_W+1:0] trial;
      rem2  = {s.rem[ROOT_W-1:0], s.rad[SQ_W-1 -: 2]};
      trial = {s.root, 2'b01};
      r.rad = {s.rad[SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = rem2 - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem2;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of restoring division.
   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [ROOT_W-1:0] len);
      div_state_type   r;
      logic [ROOT_W:0] rem2;
      logic [ROOT_W:0] diff;
      rem2  = {s.rem, s.low[ROOT_W-1]};
      diff  = rem2 - {1'b0, len};
      r.low = {s.low[ROOT_W-2:0], 1'b0};
      if (rem2 >= {1'b0, len}) begin
         r.rem = diff[ROOT_W-1:0];
         r.quo = {s.quo[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem = rem2[ROOT_W-1:0];
         r.quo = {s.quo[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- design/triangle_normal_centroid.sv -----
// Top level of the triangle unit normal and centroid pipeline.
//
// Input channel: a triangle is transferred at a clock edge with start high
// and busy low. busy is always low, so one triangle can enter every cycle.
// The payload req_data holds the three corners in signed Q16.16.
// Result channel: rsp_valid is high for exactly one cycle per triangle, and
// rsp_data then carries the unit normal in signed Q2.30, the centroid in
// Q16.16 and the degenerate flag. Results leave in input order.
// Each triangle passes the cross, norm, square root and divider stages and
// the output register; throughput is one triangle per cycle. The square
// root and the divider are each eight stages of four bits.
// A zero cross product gives a zero normal with degenerate set.
// Reset clears all valid bits; triangles in flight are dropped.
// The receiver cannot stall, so the pipeline always advances.
`include "assert_macros.svh"

module triangle_normal_centroid (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tnc_pkg::req_type req_data,
   output logic             rsp_valid,
   output tnc_pkg::rsp_type rsp_data
);
   import tnc_pkg::*;

   logic              cr_valid, nm_valid, sq_valid, dv_valid;
   cross_vec_type     cr_cross;
   side_type          cr_side, nm_side, sq_side, dv_side;
   logic [SQ_W-1:0]   nm_sq;
   mvec_type          nm_m, sq_m;
   logic [ROOT_W-1:0] sq_root;
   qvec_type          dv_q;

   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic              normal_zero;
   logic              normal_x_in_range;

   assign busy = 1'b0;

   tnc_cross u_cross (
      .clock, .reset,
      .in_valid(start & ~busy), .in_data(req_data),
      .out_valid(cr_valid), .out_cross(cr_cross), .out_side(cr_side)
   );

   tnc_norm u_norm (
      .clock, .reset,
      .in_valid(cr_valid), .in_cross(cr_cross), .in_side(cr_side),
      .out_valid(nm_valid), .out_sq(nm_sq), .out_m(nm_m), .out_side(nm_side)
   );

   tnc_sqrt u_sqrt (
      .clock, .reset,
      .in_valid(nm_valid), .in_sq(nm_sq), .in_m(nm_m), .in_side(nm_side),
      .out_valid(sq_valid), .out_root(sq_root), .out_m(sq_m), .out_side(sq_side)
   );

   tnc_div u_div (
      .clock, .reset,
      .in_valid(sq_valid), .in_len(sq_root), .in_m(sq_m), .in_side(sq_side),
      .out_valid(dv_valid), .out_q(dv_q), .out_side(dv_side)
   );

   always_comb begin
      logic [NORM_W-1:0] n [3];
      for (int i = 0; i < 3; i++) begin
         n[i] = dv_side.neg[i] ? -NORM_W'(dv_q[i]) : NORM_W'(dv_q[i]);
      end
      rsp_in.normal_x   = n[0];
      rsp_in.normal_y   = n[1];
      rsp_in.normal_z   = n[2];
      rsp_in.centroid_x = dv_side.centroid[0];
      rsp_in.centroid_y = dv_side.centroid[1];
      rsp_in.centroid_z = dv_side.centroid[2];
      rsp_in.degenerate = dv_side.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign normal_zero = (rsp_data.normal_x == '0) && (rsp_data.normal_y == '0)
                        && (rsp_data.normal_z == '0);
   assign normal_x_in_range = (rsp_data.normal_x <= 32'sd1073741824)
                              && (rsp_data.normal_x >= -32'sd1073741824);

   `ASSERT_DELAYED(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid)
   `ASSERT_IMPLIES(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, normal_zero)
   `ASSERT_IMPLIES(a_nondegen_nonzero, clock, reset, rsp_valid && !rsp_data.degenerate, !normal_zero)
   `ASSERT_IMPLIES(a_unit_range, clock, reset, rsp_valid, normal_x_in_range)
endmodule

// ----- design/tnc_cross.sv -----
// Edge vectors, cross product and centroid, three register stages.
module tnc_cross (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tnc_pkg::req_type       in_data,
   output logic                   out_valid,
   output tnc_pkg::cross_vec_type out_cross,
   output tnc_pkg::side_type      out_side
);
   import tnc_pkg::*;

   logic signed [COORD_WIDTH-1:0] p0 [3];
   logic signed [COORD_WIDTH-1:0] p1 [3];
   logic signed [COORD_WIDTH-1:0] p2 [3];

   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [PROD_W-1:0]  prod_ff [6];
   logic [CPROD_W-1:0]        cprod_ff [3];
   logic [2:0]                cneg_ff;
   logic [CPROD_W-1:0]        cprod_in [3];
   logic [2:0]                cneg_in;
   cross_vec_type             cross_ff;
   side_type                  side_ff;
   logic [CROSS_STAGES-1:0]   valid_ff;

   assign p0[0] = in_data.first_x;
   assign p0[1] = in_data.first_y;
   assign p0[2] = in_data.first_z;
   assign p1[0] = in_data.second_x;
   assign p1[1] = in_data.second_y;
   assign p1[2] = in_data.second_z;
   assign p2[0] = in_data.third_x;
   assign p2[1] = in_data.third_y;
   assign p2[2] = in_data.third_z;

   always_comb begin
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] magp1;
      for (int i = 0; i < 3; i++) begin
         cneg_in[i]  = sum_ff[i][SUM_W-1];
         mag         = cneg_in[i] ? SUM_W'(-sum_ff[i]) : SUM_W'(sum_ff[i]);
         magp1       = mag + SUM_W'(1);
         cprod_in[i] = CPROD_W'(magp1) * CPROD_W'(DIV3_MULT[MULT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[CROSS_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [COORD_WIDTH-1:0] q;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]  <= $signed({p1[i][COORD_WIDTH-1], p1[i]})
                      - $signed({p0[i][COORD_WIDTH-1], p0[i]});
         e2_ff[i]  <= $signed({p2[i][COORD_WIDTH-1], p2[i]})
                      - $signed({p0[i][COORD_WIDTH-1], p0[i]});
         sum_ff[i] <= $signed({{2{p0[i][COORD_WIDTH-1]}}, p0[i]})
                      + $signed({{2{p1[i][COORD_WIDTH-1]}}, p1[i]})
                      + $signed({{2{p2[i][COORD_WIDTH-1]}}, p2[i]});
         cprod_ff[i] <= cprod_in[i];
      end
      cneg_ff    <= cneg_in;
      prod_ff[0] <= e1_ff[1] * e2_ff[2];
      prod_ff[1] <= e1_ff[2] * e2_ff[1];
      prod_ff[2] <= e1_ff[2] * e2_ff[0];
      prod_ff[3] <= e1_ff[0] * e2_ff[2];
      prod_ff[4] <= e1_ff[0] * e2_ff[1];
      prod_ff[5] <= e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         cross_ff[i] <= CROSS_W'($signed({prod_ff[2*i][PROD_W-1], prod_ff[2*i]})
                        - $signed({prod_ff[2*i+1][PROD_W-1], prod_ff[2*i+1]}));
         q = cprod_ff[i][DIV3_SHIFT +: COORD_WIDTH];
         side_ff.centroid[i] <= cneg_ff[i] ? -q : q;
      end
      side_ff.neg        <= '0;
      side_ff.degenerate <= 1'b0;
   end

   assign out_valid = valid_ff[CROSS_STAGES-1];
   assign out_cross = cross_ff;
   assign out_side  = side_ff;
endmodule

// ----- design/tnc_norm.sv -----
// Magnitudes, shared normalizing shift and sum of squares, five register stages.
module tnc_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tnc_pkg::cross_vec_type in_cross,
   input  tnc_pkg::side_type      in_side,
   output logic                   out_valid,
   output logic [tnc_pkg::SQ_W-1:0] out_sq,
   output tnc_pkg::mvec_type      out_m,
   output tnc_pkg::side_type      out_side
);
   import tnc_pkg::*;

   logic [MAG_W-1:0]        mag1_ff [3];
   logic [MAG_W-1:0]        mag2_ff [3];
   logic [NCHUNK-1:0]       nz_ff;
   logic [3:0]              loc_ff [NCHUNK];
   logic [BL_W-1:0]         bl_ff;
   mvec_type                m3_ff, m4_ff, m5_ff;
   logic [2*M_W-1:0]        sq_ff [3];
   logic [SQ_W-1:0]         s_ff;
   side_type                side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic [NORM_STAGES-1:0]  valid_ff;

   logic [MAG_W-1:0]        mag_in [3];
   logic [2:0]              neg_in;
   logic [NCHUNK-1:0]       nz_in;
   logic [3:0]              loc_in [NCHUNK];
   logic [BL_W-1:0]         bl_in;
   mvec_type                m_in;

   always_comb begin
      logic [CROSS_W-1:0]    abs_v;
      logic [NCHUNK*8-1:0]   orw;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_cross[i][CROSS_W-1];
         abs_v     = neg_in[i] ? -in_cross[i] : in_cross[i];
         mag_in[i] = abs_v[MAG_W-1:0];
      end
      // The largest bit length of the three equals that of their OR.
      orw = (NCHUNK*8)'(mag_in[0] | mag_in[1] | mag_in[2]);
      for (int c = 0; c < NCHUNK; c++) begin
         nz_in[c]  = |orw[c*8 +: 8];
         loc_in[c] = '0;
         for (int j = 0; j < 8; j++) begin
            if (orw[c*8+j]) begin
               loc_in[c] = 4'(j + 1);
            end
         end
      end
   end

   always_comb begin
      bl_in = '0;
      for (int c = 0; c < NCHUNK; c++) begin
         if (nz_ff[c]) begin
            bl_in = BL_W'(c * 8) + BL_W'(loc_ff[c]);
         end
      end
   end

   always_comb begin
      logic [MAG_W+M_W-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         // Floor of mag * 2^31 / 2^bl covers both shift directions.
         wide    = {mag2_ff[i], {M_W{1'b0}}} >> bl_ff;
         m_in[i] = wide[M_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NORM_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= mag_in[i];
         mag2_ff[i] <= mag1_ff[i];
         sq_ff[i]   <= m3_ff[i] * m3_ff[i];
      end
      for (int c = 0; c < NCHUNK; c++) begin
         loc_ff[c] <= loc_in[c];
      end
      nz_ff    <= nz_in;
      side1_ff <= '{centroid: in_side.centroid, neg: neg_in, degenerate: 1'b0};
      bl_ff    <= bl_in;
      side2_ff <= '{centroid: side1_ff.centroid, neg: side1_ff.neg,
                    degenerate: (bl_in == '0)};
      m3_ff    <= m_in;
      side3_ff <= side2_ff;
      m4_ff    <= m3_ff;
      side4_ff <= side3_ff;
      s_ff     <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
      m5_ff    <= m4_ff;
      side5_ff <= side4_ff;
   end

   assign out_valid = valid_ff[NORM_STAGES-1];
   assign out_sq    = s_ff;
   assign out_m     = m5_ff;
   assign out_side  = side5_ff;
endmodule

// ----- design/tnc_sqrt.sv -----
// Pipelined integer square root, four result bits per stage.
module tnc_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [tnc_pkg::SQ_W-1:0]  in_sq,
   input  tnc_pkg::mvec_type         in_m,
   input  tnc_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [tnc_pkg::ROOT_W-1:0] out_root,
   output tnc_pkg::mvec_type         out_m,
   output tnc_pkg::side_type         out_side
);
   import tnc_pkg::*;

   sqrt_state_type          st_ff  [ROOT_STAGES];
   sqrt_state_type          st_src [ROOT_STAGES];
   sqrt_state_type          st_in  [ROOT_STAGES];
   mvec_type                m_ff   [ROOT_STAGES];
   mvec_type                m_src  [ROOT_STAGES];
   side_type                side_ff  [ROOT_STAGES];
   side_type                side_src [ROOT_STAGES];
   logic [ROOT_STAGES-1:0]  valid_ff;

   assign st_src[0]   = '{rem: '0, root: '0, rad: in_sq};
   assign m_src[0]    = in_m;
   assign side_src[0] = in_side;

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      if (k > 0) begin : g_link
         assign st_src[k]   = st_ff[k-1];
         assign m_src[k]    = m_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      always_comb begin
         sqrt_state_type cur;
         cur = st_src[k];
         for (int j = 0; j < STEPS; j++) begin
            cur = sqrt_step(cur);
         end
         st_in[k] = cur;
      end

      always_ff @(posedge clock) begin
         st_ff[k]   <= st_in[k];
         m_ff[k]    <= m_src[k];
         side_ff[k] <= side_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ROOT_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ROOT_STAGES-1];
   assign out_root  = st_ff[ROOT_STAGES-1].root;
   assign out_m     = m_ff[ROOT_STAGES-1];
   assign out_side  = side_ff[ROOT_STAGES-1];
endmodule

// ----- design/tnc_div.sv -----
// Three-lane pipelined divider that divides each component by the length.
module tnc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [tnc_pkg::ROOT_W-1:0] in_len,
   input  tnc_pkg::mvec_type          in_m,
   input  tnc_pkg::side_type          in_side,
   output logic                       out_valid,
   output tnc_pkg::qvec_type          out_q,
   output tnc_pkg::side_type          out_side
);
   import tnc_pkg::*;

   div_state_type [2:0]    init_ff;
   logic [ROOT_W-1:0]      len0_ff;
   side_type               side0_ff;
   logic                   valid0_ff;

   div_state_type [2:0]    st_ff   [DIV_STAGES];
   div_state_type [2:0]    st_src  [DIV_STAGES];
   div_state_type [2:0]    st_in   [DIV_STAGES];
   logic [ROOT_W-1:0]      len_ff  [DIV_STAGES];
   logic [ROOT_W-1:0]      len_src [DIV_STAGES];
   side_type               side_ff  [DIV_STAGES];
   side_type               side_src [DIV_STAGES];
   logic [DIV_STAGES-1:0]  valid_ff;

   logic [ROOT_W-1:0]      len_fix;
   div_state_type [2:0]    init_in;

   always_comb begin
      logic [2*ROOT_W-1:0] num;
      // A zero length only comes with a zero cross product.
      len_fix = (in_len == '0) ? ROOT_W'(1) : in_len;
      for (int i = 0; i < 3; i++) begin
         num = ((2*ROOT_W)'(in_m[i]) << NORM_FRAC) + (2*ROOT_W)'(len_fix >> 1);
         init_in[i].rem = num[2*ROOT_W-1:ROOT_W];
         init_in[i].low = num[ROOT_W-1:0];
         init_in[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      init_ff  <= init_in;
      len0_ff  <= len_fix;
      side0_ff <= in_side;
   end

   assign st_src[0]   = init_ff;
   assign len_src[0]  = len0_ff;
   assign side_src[0] = side0_ff;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k > 0) begin : g_link
         assign st_src[k]   = st_ff[k-1];
         assign len_src[k]  = len_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      always_comb begin
         div_state_type cur;
         for (int i = 0; i < 3; i++) begin
            cur = st_src[k][i];
            for (int j = 0; j < STEPS; j++) begin
               cur = div_step(cur, len_src[k]);
            end
            st_in[k][i] = cur;
         end
      end

      always_ff @(posedge clock) begin
         st_ff[k]   <= st_in[k];
         len_ff[k]  <= len_src[k];
         side_ff[k] <= side_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid_ff  <= '0;
      end else begin
         valid0_ff <= in_valid;
         valid_ff  <= {valid_ff[DIV_STAGES-2:0], valid0_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_q[i] = st_ff[DIV_STAGES-1][i].quo;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
endmodule
